[rtl/min_of_sliding_window_max_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window min-of-max block
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef MIN_OF_SLIDING_WINDOW_MAX_MACROS_SVH
`define MIN_OF_SLIDING_WINDOW_MAX_MACROS_SVH

// Property checked at every rising edge of clk while out of reset.
`define MSWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen while out of reset.
`define MSWM_ASSERT_NEVER(lbl, cond, msg) \
	`MSWM_ASSERT(lbl, !(cond), msg)

`endif

[rtl/mswm_pkg.sv]
// ----------------------------------------------------------------------------
// mswm_pkg
// Request and result payload types and fixed constants of the sliding window min-of-max.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mswm_pkg;

	localparam int FIELD_W = 32;
	localparam int POS_W   = 32;
	localparam int CFG_W   = 11;

	localparam logic [CFG_W-1:0] WIN_LEN_RESET = 11'd1;

	typedef struct packed {
		logic [FIELD_W-1:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] answer;
		logic               short_sequence;
	} out_item_t;

endpackage

[rtl/min_of_sliding_window_max.sv]
// Flow: an accepted request reads the deque front in S_FRONT and expires stale entries from
// it, then trims entries no greater than the new value from the back in S_BACK, pushes, and
// for a last request registers the result into the output register. A new request is taken
// only once the last one is pushed, since the single read port of the deque RAM serves one
// entry at a time; each entry is removed once. A last request waits while out is full.
// Reset: asynchronous, active low; the sequence state and window_len (1) are cleared at once.
// ----------------------------------------------------------------------------
// min_of_sliding_window_max
// Streams a sequence; returns the min of window maxima, or its max when shorter than a window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_of_sliding_window_max #(
	parameter int MAX_WINDOW = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [10:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  mswm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mswm_pkg::out_item_t out_data
);

	import mswm_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int DW = VALUE_BITS + POS_W;

	logic [CFG_W-1:0] win_len_q;
	logic [CW-1:0]    win_eff;

	logic             res_valid;
	logic             res_ready;
	out_item_t        res_data;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             mem_rd_en;
	logic [AW-1:0]    mem_rd_addr;
	logic [DW-1:0]    mem_rd_data;
	logic             mem_wr_en;
	logic [AW-1:0]    mem_wr_addr;
	logic [DW-1:0]    mem_wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WIN_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			win_len_q <= cfg_data;
		end
	end

	// A zero length acts as one; lengths above the deque depth saturate.
	always_comb begin
		if (win_len_q == '0) begin
			win_eff = CW'(1);
		end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
			win_eff = CW'(MAX_WINDOW);
		end else begin
			win_eff = CW'(win_len_q);
		end
	end

	mswm_seq #(
		.MAX_WINDOW (MAX_WINDOW),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW),
		.CW         (CW),
		.DW         (DW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.win_eff     (win_eff),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	mswm_ram #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW),
		.DW    (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// The output register frees the sequencer while a result waits.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/mswm_ram.sv]
// ----------------------------------------------------------------------------
// mswm_ram
// Simple dual-port synchronous RAM holding the deque entries, with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mswm_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/mswm_seq.sv]
// ----------------------------------------------------------------------------
// mswm_seq
// Deque sequencer: expires the front, trims the back, pushes and tracks the
// running minimum of window maxima and the running maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mswm_seq #(
	parameter int MAX_WINDOW = 1024,
	parameter int VALUE_BITS = 32,
	parameter int AW         = 10,
	parameter int CW         = 11,
	parameter int DW         = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CW-1:0]       win_eff,
	input  logic                in_valid,
	output logic                in_ready,
	input  mswm_pkg::in_item_t  in_data,
	output logic                res_valid,
	input  logic                res_ready,
	output mswm_pkg::out_item_t res_data,
	output logic                mem_rd_en,
	output logic [AW-1:0]       mem_rd_addr,
	input  logic [DW-1:0]       mem_rd_data,
	output logic                mem_wr_en,
	output logic [AW-1:0]       mem_wr_addr,
	output logic [DW-1:0]       mem_wr_data
);

	import mswm_pkg::*;

	`include "min_of_sliding_window_max_macros.svh"

	localparam int SW = CW + 1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FRONT = 3'b010,
		S_BACK  = 3'b100
	} seq_state_t;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
					       input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(MAX_WINDOW)) begin
			sum = sum - SW'(MAX_WINDOW);
		end
		return AW'(sum);
	endfunction

	seq_state_t            state_q, state_d;
	logic [AW-1:0]         head_q, head_d;
	logic [CW-1:0]         count_q, count_d;
	logic [POS_W-1:0]      pos_q, pos_d;
	logic [VALUE_BITS-1:0] best_q, best_d;
	logic [VALUE_BITS-1:0] omax_q, omax_d;
	logic                  filled_q, filled_d;
	logic [VALUE_BITS-1:0] hval_q, hval_d;

	// Request being worked on.
	logic [VALUE_BITS-1:0] v_q;
	logic                  last_q;
	logic [CW-1:0]         w_q;
	logic [POS_W-1:0]      p_q;

	logic [VALUE_BITS-1:0] rd_val;
	logic [POS_W-1:0]      rd_pos;
	logic [AW-1:0]         head_next;
	logic                  expired;
	logic                  tail_pop;
	logic                  push_ok;
	logic [VALUE_BITS-1:0] head_now;
	logic                  filled_now;
	logic [VALUE_BITS-1:0] best_now;
	logic [VALUE_BITS-1:0] omax_now;

	assign rd_val    = mem_rd_data[DW-1:POS_W];
	assign rd_pos    = mem_rd_data[POS_W-1:0];
	assign head_next = slot(head_q, CW'(1));

	// Wrapped distance keeps expiry right across position overflow.
	assign expired  = (count_q != '0) && ((p_q - rd_pos) >= POS_W'(w_q));
	assign tail_pop = (count_q != '0) && (rd_val <= v_q);
	assign push_ok  = (count_q != CW'(MAX_WINDOW));

	// Once the back is trimmed, the head entry is the new value only if the
	// deque was emptied; otherwise it is the one read in the front phase.
	assign head_now   = (count_q == '0) ? v_q : hval_q;
	assign filled_now = filled_q | (({1'b0, p_q} + 33'd1) >= 33'(w_q));
	assign best_now   = (filled_now && (head_now < best_q)) ? head_now : best_q;
	assign omax_now   = (v_q > omax_q) ? v_q : omax_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		pos_d       = pos_q;
		best_d      = best_q;
		omax_d      = omax_q;
		filled_d    = filled_q;
		hval_d      = hval_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = head_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = slot(head_q, count_q);
		mem_wr_data = {v_q, p_q};
		res_valid   = 1'b0;
		res_data.answer         = filled_now ? FIELD_W'(best_now) : FIELD_W'(omax_now);
		res_data.short_sequence = !filled_now;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = head_q;
					state_d     = S_FRONT;
				end
			end
			S_FRONT: begin
				if (expired) begin
					head_d      = head_next;
					count_d     = count_q - CW'(1);
					mem_rd_en   = (count_q > CW'(1));
					mem_rd_addr = head_next;
				end else begin
					hval_d      = rd_val;
					mem_rd_en   = (count_q != '0);
					mem_rd_addr = slot(head_q, count_q - CW'(1));
					state_d     = S_BACK;
				end
			end
			S_BACK: begin
				if (tail_pop) begin
					count_d     = count_q - CW'(1);
					mem_rd_en   = (count_q > CW'(1));
					mem_rd_addr = slot(head_q, count_q - CW'(2));
				end else if (!last_q || res_ready) begin
					mem_wr_en = push_ok;
					count_d   = push_ok ? (count_q + CW'(1)) : count_q;
					pos_d     = p_q + POS_W'(1);
					best_d    = best_now;
					omax_d    = omax_now;
					filled_d  = filled_now;
					state_d   = S_IDLE;
					if (last_q) begin
						res_valid = 1'b1;
						head_d    = '0;
						count_d   = '0;
						pos_d     = '0;
						best_d    = '1;
						omax_d    = '0;
						filled_d  = 1'b0;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			best_q   <= '1;
			omax_q   <= '0;
			filled_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			pos_q    <= pos_d;
			best_q   <= best_d;
			omax_q   <= omax_d;
			filled_q <= filled_d;
		end
	end

	always_ff @(posedge clk) begin
		hval_q <= hval_d;
		if (in_valid && in_ready) begin
			v_q    <= VALUE_BITS'(in_data.value);
			last_q <= in_data.last;
			w_q    <= win_eff;
			p_q    <= pos_q;
		end
	end

	`MSWM_ASSERT(a_count_bound, count_q <= CW'(MAX_WINDOW), "deque count above depth")
	`MSWM_ASSERT(a_head_range, head_q < AW'(MAX_WINDOW - 1) || head_q == AW'(MAX_WINDOW - 1), "head out of range")
	`MSWM_ASSERT_NEVER(a_rw_overlap, mem_wr_en && mem_rd_en, "read and write in one cycle")
	`MSWM_ASSERT(a_res_taken, res_valid |-> (res_ready && last_q && state_q == S_BACK), "result while output busy")
	`MSWM_ASSERT(a_accept_front, (in_valid && in_ready) |=> (state_q == S_FRONT), "accepted request not started")

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for min_of_sliding_window_max
// Streams sequences of unsigned values through the block under several window
// lengths and compares each answer with an in-bench streaming predictor. A
// short table of directed requests comes first, then random sequences under
// three idling patterns, a long output stall and one maximum-window sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import mswm_pkg::*;

	localparam int MAX_WIN     = 1024;
	localparam int DRAIN       = 2 * MAX_WIN + 16;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 200;
	localparam int DIR_ROWS    = 24;

	typedef struct packed {
		bit          set_win;
		logic [10:0] win;
		logic [31:0] value;
		bit          last;
		bit          typed;
		logic [31:0] answer;
		bit          short_seq;
	} dir_row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [10:0]     cfg_data = '0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	in_item_t        in_data = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	out_item_t       out_data;

	// Predictor state
	logic [31:0]     dq_val [MAX_WIN];
	logic [31:0]     dq_pos [MAX_WIN];
	int unsigned     dq_head;
	int unsigned     dq_count;
	logic [31:0]     seq_pos;
	logic [31:0]     best_max;
	logic [31:0]     peak;
	bit              filled;
	logic [10:0]     win_len_reg;

	out_item_t       answers_due [$];
	dir_row_t        directed_rows [DIR_ROWS];
	int              mismatch_count = 0;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	int              stall_asked = 0;
	int              stall_done = 0;
	int              phase_items;

	min_of_sliding_window_max #(
		.MAX_WINDOW(MAX_WIN),
		.VALUE_BITS(32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #6 clk = ~clk;

	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic void clear_seq();
		dq_head = 0;
		dq_count = 0;
		seq_pos = '0;
		best_max = '1;
		peak = '0;
		filled = 1'b0;
	endfunction

	// Advances the streaming model by one value; returns 1 when an answer is due.
	function automatic bit fold_value(input logic [31:0] v, input bit is_last,
			output out_item_t res);
		int unsigned w;
		int unsigned slot;
		logic [31:0] p;
		w = (win_len_reg == 0) ? 1 : (win_len_reg > MAX_WIN) ? MAX_WIN : win_len_reg;
		p = seq_pos;
		while (dq_count > 0 && (p - dq_pos[dq_head]) >= w) begin
			dq_head = (dq_head + 1) % MAX_WIN;
			dq_count--;
		end
		while (dq_count > 0 && dq_val[(dq_head + dq_count - 1) % MAX_WIN] <= v)
			dq_count--;
		if (dq_count < MAX_WIN) begin
			slot = (dq_head + dq_count) % MAX_WIN;
			dq_val[slot] = v;
			dq_pos[slot] = p;
			dq_count++;
		end
		if (v > peak)
			peak = v;
		if ({1'b0, p} + 33'd1 >= {1'b0, w})
			filled = 1'b1;
		if (filled && dq_val[dq_head] < best_max)
			best_max = dq_val[dq_head];
		seq_pos = p + 32'd1;
		if (!is_last)
			return 1'b0;
		res.answer = filled ? best_max : peak;
		res.short_sequence = !filled;
		clear_seq();
		return 1'b1;
	endfunction

	function automatic logic [10:0] pick_window();
		int unsigned r;
		r = $urandom_range(19);
		case (r)
			0: return 11'd0;
			1: return 11'd2047;
			2: return 11'd1024;
			3: return 11'($urandom_range(2047));
			default: return 11'($urandom_range(8, 1));
		endcase
	endfunction

	// The block may still be working on a request with no answer, hence the tail wait.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_window(input logic [10:0] len);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do @(posedge clk); while (!cfg_ready);
		win_len_reg = len;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input logic [31:0] v, input bit is_last, input bit typed,
			input out_item_t typed_res);
		out_item_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{value: v, last: is_last};
		do @(posedge clk); while (!in_ready);
		if (fold_value(v, is_last, res)) begin
			if (typed)
				res = typed_res;
			answers_due = {answers_due, res};
		end
		@(negedge clk);
	endtask

	task automatic run_sequence();
		int unsigned w;
		int unsigned len;
		int unsigned mode;
		logic [31:0] cur;
		logic [31:0] v;
		w = (win_len_reg == 0) ? 1 : (win_len_reg > MAX_WIN) ? MAX_WIN : win_len_reg;
		len = (w <= 16) ? $urandom_range(3 * w + 4, 1) : $urandom_range(24, 1);
		mode = $urandom_range(5);
		cur = $urandom;
		for (int unsigned i = 0; i < len; i++) begin
			case (mode)
				0: v = $urandom;
				1: v = $urandom_range(7);
				2: begin
					cur = cur - $urandom_range(3);
					v = cur;
				end
				3: begin
					cur = cur + $urandom_range(3);
					v = cur;
				end
				4: v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				default: v = 32'hFFFF_FFF8 | $urandom_range(7);
			endcase
			send_item(v, i == len - 1, 1'b0, '0);
			phase_items++;
			// Occasionally move the window while a sequence is under way.
			if (i < len - 1 && $urandom_range(49) == 0)
				write_window(pick_window());
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (stall_done != stall_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				stall_done++;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				$display("%0t: answer with none expected: answer %h short_sequence %b",
					$time, out_data.answer, out_data.short_sequence);
				mismatch_count++;
			end else begin
				want = answers_due.pop_front();
				if (out_data.answer !== want.answer) begin
					$display("%0t: answer expected %h actual %h",
						$time, want.answer, out_data.answer);
					mismatch_count++;
				end
				if (out_data.short_sequence !== want.short_sequence) begin
					$display("%0t: short_sequence expected %b actual %b",
						$time, want.short_sequence, out_data.short_sequence);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		dir_row_t row;
		win_len_reg = WIN_LEN_RESET;
		clear_seq();

		// Window 1 after reset, the value extremes, zero and oversized windows,
		// equal values, a short sequence and window changes mid-sequence.
		directed_rows = '{
			'{0, 11'd0,    32'h0000_0000, 1, 1, 32'h0000_0000, 0},
			'{0, 11'd0,    32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 0},
			'{1, 11'd0,    32'd5,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd3,         1, 1, 32'd3,         0},
			'{1, 11'd2047, 32'd7,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd9,         1, 1, 32'd9,         1},
			'{1, 11'd1024, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1},
			'{1, 11'd3,    32'd5,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd1,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd2,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd8,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd0,         1, 0, 32'd0,         0},
			'{1, 11'd2,    32'd4,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd4,         1, 1, 32'd4,         0},
			'{1, 11'd3,    32'd1,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd2,         1, 1, 32'd2,         1},
			'{1, 11'd4,    32'd1,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd9,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd3,         0, 0, 32'd0,         0},
			'{1, 11'd1,    32'd2,         1, 0, 32'd0,         0},
			'{1, 11'd2,    32'd6,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd1,         0, 0, 32'd0,         0},
			'{1, 11'd5,    32'd7,         0, 0, 32'd0,         0},
			'{0, 11'd0,    32'd0,         1, 0, 32'd0,         0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.set_win)
				write_window(row.win);
			send_item(row.value, row.last, row.typed,
				'{answer: row.answer, short_sequence: row.short_seq});
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 55 : 0;
			recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 33 : 0;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(3) == 0)
					write_window(pick_window());
				if (phase == 0 && stall_asked == 0 && phase_items > 100) begin
					// Hold the output off while one-value sequences keep arriving.
					stall_asked++;
					for (int n = 0; n < 30; n++)
						send_item($urandom, 1'b1, 1'b0, '0);
				end
				if (phase == 1 && phase_items > 100 && $urandom_range(9) == 0)
					wait_drained();
				run_sequence();
			end
		end

		// Full-size window: a falling run builds a deep deque, then a lower rising tail
		// trims only its own entries from the back; the sequence stays shorter than the window.
		write_window(11'd1024);
		for (int i = 0; i < 100; i++)
			send_item(32'hFFFF_FFFF - i, 1'b0, 1'b0, '0);
		for (int i = 0; i < 20; i++)
			send_item(32'hFFFF_F000 + 64 * i + $urandom_range(63), i == 19, 1'b0, '0);

		wait_drained();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/mswm_pkg.sv
rtl/mswm_ram.sv
rtl/mswm_seq.sv
rtl/min_of_sliding_window_max.sv
bench/testbench.sv
